/* hdl/utf8_stream_validator_defines.svh */
// Assertion macros shared by the verification files of the UTF-8 stream validator.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define USV_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define USV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define USV_ASSERT_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

/* hdl/usv_pkg.sv */
// Shared types and constants of the UTF-8 stream validator.
// No dependencies; used by usv_step, utf8_stream_validator, usv_status_checker and the testbench.
package usv_pkg;

   // Status codes reported on the final byte of a string
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_STRAY     = 3'd1,
      ERR_TRUNC     = 3'd2,
      ERR_OVERLONG  = 3'd3,
      ERR_SURROGATE = 3'd4,
      ERR_RANGE     = 3'd5,
      ERR_BAD_LEAD  = 3'd6
   } usv_status_type;

   // Byte thresholds
   localparam logic [7:0] LEAD_MIN_TWO  = 8'hC2;
   localparam logic [7:0] LEAD_OVL_3B   = 8'hE0;
   localparam logic [7:0] LEAD_SURR     = 8'hED;
   localparam logic [7:0] LEAD_OVL_4B   = 8'hF0;
   localparam logic [7:0] LEAD_MAX_FOUR = 8'hF4;
   localparam logic [7:0] CONT_MIN_E0   = 8'hA0;
   localparam logic [7:0] CONT_MIN_F0   = 8'h90;

   // Per-string decoder state
   typedef struct packed {
      logic [1:0]     bytes_owed;
      logic [7:0]     lead_value;
      usv_status_type held_error;
      usv_status_type first_error;
   } usv_state_type;

endpackage

/* hdl/utf8_stream_validator.sv */
// UTF-8 stream validator: takes one byte per cycle and reports one status on
// each byte flagged last. A byte is held in the input register, then its status
// in the result register; the per-byte state update feeds straight back into the
// state register, so a new byte is taken every cycle while the input is not held.
// Only while a status waits stalled in the result register does a final byte hold the input.
// Depends on usv_pkg and usv_step.
module utf8_stream_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status
);

   logic                   in_vld_ff, in_vld_in;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   usv_pkg::usv_state_type state_ff, state_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;

   usv_pkg::usv_state_type step_state;
   usv_pkg::usv_status_type step_status;
   logic                   rsp_free;
   logic                   advance;

   // Byte in the input register moves on unless its status has nowhere to go
   assign rsp_free  = !rsp_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && (!in_last_ff || rsp_free);
   assign req_stall = in_vld_ff && !advance;

   usv_step u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt_state (step_state),
      .status    (step_status)
   );

   // Next values
   always_comb begin
      in_vld_in     = req_stall ? in_vld_ff : req_valid;
      state_in      = advance ? step_state : state_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      if (advance && in_last_ff) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = step_status;
      end else if (!rsp_stall) begin
         rsp_vld_in    = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         state_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* hdl/usv_step.sv */
// Next-state and status logic for one byte of the UTF-8 stream validator.
// Depends on usv_pkg.
module usv_step (
   input  usv_pkg::usv_state_type  cur_state,
   input  logic [7:0]              data_byte,
   input  logic                    last_byte,
   output usv_pkg::usv_state_type  nxt_state,
   output usv_pkg::usv_status_type status
);

   usv_pkg::usv_state_type st;
   logic                   is_second;

   // First continuation of a multi-byte character
   always_comb begin
      if (cur_state.lead_value >= usv_pkg::LEAD_OVL_4B) begin
         is_second = (cur_state.bytes_owed == 2'd3);
      end else if (cur_state.lead_value >= usv_pkg::LEAD_OVL_3B) begin
         is_second = (cur_state.bytes_owed == 2'd2);
      end else begin
         is_second = (cur_state.bytes_owed == 2'd1);
      end
   end

   // Byte decode; nothing changes once an error is recorded
   always_comb begin
      st     = cur_state;
      status = usv_pkg::ERR_NONE;
      if (st.first_error == usv_pkg::ERR_NONE) begin
         if (st.bytes_owed != 2'd0) begin
            if (data_byte[7:6] != 2'b10) begin
               st.first_error = usv_pkg::ERR_TRUNC;
            end else begin
               // held error: only the first one of the character is kept
               if (is_second && st.held_error == usv_pkg::ERR_NONE) begin
                  if (st.lead_value == usv_pkg::LEAD_OVL_3B &&
                      data_byte < usv_pkg::CONT_MIN_E0) begin
                     st.held_error = usv_pkg::ERR_OVERLONG;
                  end else if (st.lead_value == usv_pkg::LEAD_SURR &&
                               data_byte >= usv_pkg::CONT_MIN_E0) begin
                     st.held_error = usv_pkg::ERR_SURROGATE;
                  end else if (st.lead_value == usv_pkg::LEAD_OVL_4B &&
                               data_byte < usv_pkg::CONT_MIN_F0) begin
                     st.held_error = usv_pkg::ERR_OVERLONG;
                  end else if (st.lead_value == usv_pkg::LEAD_MAX_FOUR &&
                               data_byte >= usv_pkg::CONT_MIN_F0) begin
                     st.held_error = usv_pkg::ERR_RANGE;
                  end
               end
               st.bytes_owed = st.bytes_owed - 2'd1;
               // character complete: release the held error
               if (st.bytes_owed == 2'd0 && st.held_error != usv_pkg::ERR_NONE) begin
                  st.first_error = st.held_error;
               end
            end
         end else begin
            // lead byte
            st.held_error = usv_pkg::ERR_NONE;
            st.lead_value = data_byte;
            if (data_byte inside {[8'h80:8'hBF]}) begin
               st.first_error = usv_pkg::ERR_STRAY;
            end else if (data_byte inside {[8'hC0:8'hDF]}) begin
               if (data_byte < usv_pkg::LEAD_MIN_TWO) begin
                  st.held_error = usv_pkg::ERR_OVERLONG;
               end
               st.bytes_owed = 2'd1;
            end else if (data_byte inside {[8'hE0:8'hEF]}) begin
               st.bytes_owed = 2'd2;
            end else if (data_byte inside {[8'hF0:8'hF7]}) begin
               if (data_byte > usv_pkg::LEAD_MAX_FOUR) begin
                  st.held_error = usv_pkg::ERR_RANGE;
               end
               st.bytes_owed = 2'd3;
            end else if (data_byte inside {[8'hF8:8'hFF]}) begin
               st.first_error = usv_pkg::ERR_BAD_LEAD;
            end
         end
      end
      // end of string: report and start over
      if (last_byte) begin
         if (st.first_error == usv_pkg::ERR_NONE && st.bytes_owed != 2'd0) begin
            status = usv_pkg::ERR_TRUNC;
         end else begin
            status = st.first_error;
         end
         st = '0;
      end
   end

   assign nxt_state = st;

endmodule

/* hdl/usv_checker.sv */
// Port-level checks for utf8_stream_validator, attached by bind.
// Depends on utf8_stream_validator_defines.svh.
`include "utf8_stream_validator_defines.svh"

module usv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status
);

   // Result register empties on reset
   `USV_ASSERT_RESET(a_rst_empty, !rsp_valid, "rsp_valid set after reset")

   // Only defined status codes leave the block
   `USV_ASSERT_SAME(a_status_code, rsp_valid, rsp_status != 3'd7, "undefined status code")

   // Input holds only behind a stalled status
   `USV_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid && rsp_stall,
                    "input stalled with result side free")

   // Stalled status is kept
   `USV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status),
                    "stalled status changed")

endmodule

bind utf8_stream_validator usv_checker u_usv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status)
);

/* test/usv_status_checker.sv */
// Status checker for the UTF-8 stream validator: watches both channels, predicts the
// status of every string from the accepted bytes and compares it with each result transfer.
// Depends on usv_pkg.
module usv_status_checker
   import usv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_status,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Lead byte class boundaries
   localparam logic [7:0] FIRST_CONT  = 8'h80;
   localparam logic [7:0] FIRST_TWO   = 8'hC0;
   localparam logic [7:0] FIRST_THREE = 8'hE0;
   localparam logic [7:0] FIRST_FOUR  = 8'hF0;
   localparam logic [7:0] FIRST_BAD   = 8'hF8;

   // Decoder state of the string in flight
   logic [1:0]     owed;
   logic [7:0]     lead_byte;
   usv_status_type held_code;
   usv_status_type first_code;

   usv_status_type expected_status[$];
   usv_status_type predicted;
   usv_status_type wanted;
   logic           produced;
   int             errors;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      errors        = 0;
   end

   // Keep only the first held error of a character
   function automatic usv_status_type keep_first(input usv_status_type held,
                                                 input usv_status_type found);
      return (held == ERR_NONE) ? found : held;
   endfunction

   // Fold one byte into the string state; a final byte yields the status
   task automatic absorb_byte(input logic [7:0] value, input logic fin,
                              output logic emitted, output usv_status_type status);
      logic second;
      emitted = 1'b0;
      status  = ERR_NONE;
      second  = 1'b0;
      if (first_code == ERR_NONE) begin
         if (owed != 2'd0) begin
            if (value[7:6] != 2'b10) begin
               first_code = ERR_TRUNC;
            end else begin
               // second byte of the character: owed is one less than the lead's count
               if (lead_byte >= FIRST_FOUR) second = (owed == 2'd3);
               else if (lead_byte >= FIRST_THREE) second = (owed == 2'd2);
               else second = (owed == 2'd1);
               if (second) begin
                  if (lead_byte == LEAD_OVL_3B && value < CONT_MIN_E0)
                     held_code = keep_first(held_code, ERR_OVERLONG);
                  if (lead_byte == LEAD_SURR && value >= CONT_MIN_E0)
                     held_code = keep_first(held_code, ERR_SURROGATE);
                  if (lead_byte == LEAD_OVL_4B && value < CONT_MIN_F0)
                     held_code = keep_first(held_code, ERR_OVERLONG);
                  if (lead_byte == LEAD_MAX_FOUR && value >= CONT_MIN_F0)
                     held_code = keep_first(held_code, ERR_RANGE);
               end
               owed = owed - 2'd1;
               if (owed == 2'd0 && held_code != ERR_NONE) first_code = held_code;
            end
         end else begin
            // new character
            held_code = ERR_NONE;
            lead_byte = value;
            if (value < FIRST_CONT) begin
               owed = 2'd0;
            end else if (value < FIRST_TWO) begin
               first_code = ERR_STRAY;
            end else if (value < FIRST_THREE) begin
               if (value < LEAD_MIN_TWO) held_code = ERR_OVERLONG;
               owed = 2'd1;
            end else if (value < FIRST_FOUR) begin
               owed = 2'd2;
            end else if (value < FIRST_BAD) begin
               if (value > LEAD_MAX_FOUR) held_code = ERR_RANGE;
               owed = 2'd3;
            end else begin
               first_code = ERR_BAD_LEAD;
            end
         end
      end
      if (fin) begin
         // a character cut short by the end of the string
         if (first_code == ERR_NONE && owed != 2'd0) first_code = ERR_TRUNC;
         emitted    = 1'b1;
         status     = first_code;
         owed       = 2'd0;
         lead_byte  = 8'h00;
         held_code  = ERR_NONE;
         first_code = ERR_NONE;
      end
   endtask

   // Result side first, then the byte taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         owed       = 2'd0;
         lead_byte  = 8'h00;
         held_code  = ERR_NONE;
         first_code = ERR_NONE;
         expected_status.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected status transfer, expected none, got %0d",
                        $realtime, rsp_status);
               errors++;
            end else begin
               wanted = expected_status.pop_front();
               if (rsp_status !== wanted) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $realtime, wanted, rsp_status);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            absorb_byte(req_data_byte, req_last_byte, produced, predicted);
            if (produced) expected_status.push_back(predicted);
         end
      end
      pending_count <= expected_status.size();
      fail_count    <= errors;
   end

endmodule

/* test/utf8_stream_validator_tb.sv */
// Top of the UTF-8 stream validator test: clock, reset, byte strings and result stalls.
// Checking is done by usv_status_checker; depends on usv_pkg and utf8_stream_validator.
module utf8_stream_validator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import usv_pkg::*;

   localparam int RANDOM_BYTES = 400;
   localparam int CALM_TAIL    = 60;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [2:0] rsp_status;
   int         fail_count;
   int         pending_count;

   bit         idle_on    = 1'b1;
   int         bytes_sent = 0;
   logic [7:0] text_bytes[$];

   always #2 clock = ~clock;

   utf8_stream_validator u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status)
   );

   usv_status_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // One byte transfer, preceded by an occasional idle burst
   task automatic send_byte(input logic [7:0] value, input logic fin);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the queued string, flagging its final byte
   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++)
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      text_bytes.delete();
   endtask

   // Directed string of up to four bytes, first byte in the top used lane
   task automatic send_packed(input int count, input logic [31:0] word);
      for (int i = count - 1; i >= 0; i--) text_bytes.push_back(word[i*8 +: 8]);
      send_text();
   endtask

   // Mostly well-formed characters, the rest suspicious leads with ragged tails
   task automatic build_random_string();
      int         chars;
      int         pick;
      int         tail;
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      chars = $urandom_range(1, 4);
      for (int k = 0; k < chars; k++) begin
         pick = $urandom_range(0, 99);
         lo   = 8'h80;
         hi   = 8'hBF;
         if (pick < 65) begin
            case ($urandom_range(1, 4))
               1: text_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
               2: begin
                  text_bytes.push_back(8'($urandom_range(LEAD_MIN_TWO, 8'hDF)));
                  text_bytes.push_back(8'($urandom_range(lo, hi)));
               end
               3: begin
                  lead = 8'($urandom_range(8'hE0, 8'hEF));
                  if (lead == LEAD_OVL_3B) lo = CONT_MIN_E0;
                  if (lead == LEAD_SURR) hi = 8'h9F;
                  text_bytes.push_back(lead);
                  text_bytes.push_back(8'($urandom_range(lo, hi)));
                  text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
               end
               default: begin
                  lead = 8'($urandom_range(LEAD_OVL_4B, LEAD_MAX_FOUR));
                  if (lead == LEAD_OVL_4B) lo = CONT_MIN_F0;
                  if (lead == LEAD_MAX_FOUR) hi = 8'h8F;
                  text_bytes.push_back(lead);
                  text_bytes.push_back(8'($urandom_range(lo, hi)));
                  repeat (2) text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
               end
            endcase
         end else begin
            if (pick < 85) begin
               case ($urandom_range(0, 9))
                  0: lead = 8'hC0;
                  1: lead = 8'hC1;
                  2: lead = 8'hDF;
                  3: lead = LEAD_OVL_3B;
                  4: lead = LEAD_SURR;
                  5: lead = 8'hEF;
                  6: lead = LEAD_OVL_4B;
                  7: lead = LEAD_MAX_FOUR;
                  8: lead = 8'hF5;
                  default: lead = 8'hF7;
               endcase
            end else begin
               lead = 8'($urandom_range(8'h00, 8'hFF));
            end
            // continuation count the lead asks for, sometimes a wrong one
            if (lead >= 8'hF8 || lead < 8'hC0) tail = 0;
            else if (lead >= 8'hF0) tail = 3;
            else if (lead >= 8'hE0) tail = 2;
            else tail = 1;
            if ($urandom_range(0, 3) == 0) tail = $urandom_range(0, 3);
            text_bytes.push_back(lead);
            repeat (tail) begin
               if ($urandom_range(0, 9) == 0)
                  text_bytes.push_back(8'($urandom_range(8'h00, 8'hFF)));
               else
                  text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
         end
      end
   endtask

   // Result side stall bursts
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed strings
      send_packed(1, 32'h00);           // single ASCII byte
      send_packed(1, 32'h80);           // stray continuation
      send_packed(1, 32'hFF);           // impossible lead
      send_packed(2, 32'hC1_41);        // bad continuation beats overlong lead
      send_packed(3, 32'hE0_9F_80);     // three-byte overlong
      send_packed(3, 32'hED_A0_BF);     // surrogate
      send_packed(4, 32'hF0_8F_80_80);  // four-byte overlong
      send_packed(4, 32'hF4_90_80_80);  // above U+10FFFF
      send_packed(2, 32'hF5_80);        // truncation beats held range error
      send_packed(2, 32'hF8_C2);        // error sticks, rest ignored
      send_packed(4, 32'h7F_EF_BF_BF);  // valid, widest bytes

      // random strings, calm at the end
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         if (bytes_sent > RANDOM_BYTES - CALM_TAIL) idle_on = 1'b0;
         else if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
         build_random_string();
         send_text();
      end
      req_valid <= 1'b0;

      // drain the outstanding statuses, then let the design settle before the verdict
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS utf8_stream_validator");
      else
         $display("FAIL utf8_stream_validator");
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("FAIL utf8_stream_validator");
      $finish;
   end

endmodule
